[design/sspe_pkg.sv]
`timescale 1ns / 1ps
package sspe_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  // register map, index is paddr[4:3]
  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_LEVEL  = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  localparam logic [15:0] RATE_SCALE_RST = 16'd16384;

  // 2^x polynomial coefficients, Q30
  localparam logic signed [32:0] EXP_C1  = 33'sd744261118;
  localparam logic signed [32:0] EXP_C2  = 33'sd257941248;
  localparam logic signed [32:0] EXP_C3  = 33'sd59597083;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

  // ceil(2^33 / 3), exact floor(x / 3) for x below 2^32 after a 33-bit shift
  localparam logic signed [32:0] DIV3_M  = 33'sd2863311531;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RETRIG, ST_RT_MUL, ST_RT_USE, ST_BRANCH, ST_LOG_NORM,
    ST_LOG_MUL, ST_LOG_USE, ST_DIV_INIT, ST_DIV, ST_DIV_END, ST_REL_ADV,
    ST_ADV_MUL, ST_ADV_USE, ST_MOVE, ST_GAIN, ST_EXP_MUL, ST_EXP_ADD,
    ST_EXP_SH, ST_OUT_MUL, ST_OUT_RND, ST_FINISH
  } state_t;

  // mantissa shifted by three bits per exponent step below 3
  function automatic logic [14:0] rate_raw(input logic [7:0] b);
    logic [14:0] r;
    r = 15'd0;
    case (b[7:6])
      2'd0: r = {b[5:0], 9'd0};
      2'd1: r = {3'd0, b[5:0], 6'd0};
      2'd2: r = {6'd0, b[5:0], 3'd0};
      default: r = {9'd0, b[5:0]};
    endcase
    return r;
  endfunction

endpackage

[design/six_stage_patch_envelope.sv]
`timescale 1ns / 1ps
// Six-stage patch envelope applied to one audio sample per request. Stages
// 0-2 ramp linearly while the gate is held; at gate-off the level moves to
// the log domain and stages 3-5 run there with gain 2^(6v-6). All multiplies
// go through one shared 33x33 signed multiplier under a sequencer. The sample
// that converts to the log domain takes up to 30 normalize shifts, 30 squaring
// passes for log2, and a divide by six done by compares and a reciprocal
// multiply. s_tready is high only while the sequencer is idle; a finished
// result waits in the output register while the next sample is taken, and
// the sequencer stalls at its last step while that register is still full.
module six_stage_patch_envelope
  import sspe_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IW = ((SAMPLE_BITS + 3 + 7) / 8) * 8,
  localparam int OW = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [IW-1:0] s_tdata,   // gate, retrigger, audio_in, activity bit
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [OW-1:0] m_tdata,   // audio_out, done_res
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [35:0] SMAX = (36'sd1 <<< (SB - 1)) - 36'sd1;
  localparam logic signed [35:0] SMIN = -(36'sd1 <<< (SB - 1));

  // configuration
  logic [47:0] rate_codes;
  logic [47:0] level_codes;
  logic        envelope_enable;
  logic [15:0] rate_scale;

  // envelope state
  logic signed [31:0] level;
  logic [2:0]         stage;
  logic signed [31:0] step_rate;
  logic               released;
  logic               last_retrigger;

  // latched request
  logic                 gate;
  logic                 retrig;
  logic signed [SB-1:0] sample;
  logic                 agate;

  state_t state, state_next;
  logic   adv_ret;

  logic signed [32:0] a_op, b_op;
  logic signed [65:0] prod;

  logic [30:0]        m;
  logic [4:0]         k;
  logic [29:0]        frac;
  logic [5:0]         cnt;
  logic [34:0]        dq;
  logic               neg;
  logic signed [5:0]  n_exp;
  logic signed [30:0] x_exp;
  logic signed [32:0] p;
  logic signed [32:0] gain;

  logic [SB-1:0] out_audio;
  logic          out_done;
  logic [SB-1:0] res;
  logic          res_done;

  wire cfg_wr = psel && penable && pwrite && pready;
  wire out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:3])
      REG_RATE:   prdata = {16'd0, rate_codes};
      REG_LEVEL:  prdata = {16'd0, level_codes};
      REG_ENABLE: prdata = {63'd0, envelope_enable};
      default:    prdata = {48'd0, rate_scale};
    endcase
  end

  // per-stage codes
  logic [7:0]         rate_byte;
  logic [29:0]        target;
  logic signed [32:0] tgt33;
  assign rate_byte = rate_codes[8*stage +: 8];
  assign target    = {level_codes[8*stage +: 8], 22'd0};
  assign tgt33     = $signed({3'd0, target});

  // linear move
  logic signed [32:0] nv;
  logic               hit;
  logic signed [31:0] nv_sat;
  assign nv  = {level[31], level} + {step_rate[31], step_rate};
  assign hit = (nv > tgt33) != step_rate[31];
  always_comb begin
    if (nv[32] != nv[31]) nv_sat = nv[32] ? 32'sh80000000 : 32'sh7fffffff;
    else nv_sat = nv[31:0];
  end

  // log2 helpers
  logic [32:0]        mm;
  logic signed [35:0] lg;
  logic [5:0]         kd;
  logic signed [35:0] qs;
  assign mm = prod[62:30];
  assign kd = {1'b0, k} - 6'd24;
  assign lg = $signed({kd, frac});

  // divide by six: integer part by compares, the rest by a reciprocal multiply
  logic [2:0]  qhi;
  logic [2:0]  rhi;
  logic [32:0] qmag;
  always_comb begin
    qhi = 3'd0;
    rhi = dq[32:30];
    if (dq[34:30] >= 5'd30) begin
      qhi = 3'd5;
      rhi = 3'(dq[34:30] - 5'd30);
    end else if (dq[34:30] >= 5'd24) begin
      qhi = 3'd4;
      rhi = 3'(dq[34:30] - 5'd24);
    end else if (dq[34:30] >= 5'd18) begin
      qhi = 3'd3;
      rhi = 3'(dq[34:30] - 5'd18);
    end else if (dq[34:30] >= 5'd12) begin
      qhi = 3'd2;
      rhi = 3'(dq[34:30] - 5'd12);
    end else if (dq[34:30] >= 5'd6) begin
      qhi = 3'd1;
      rhi = 3'(dq[34:30] - 5'd6);
    end
  end
  assign qmag = {qhi, prod[62:33]};
  assign qs   = neg ? -$signed({3'd0, qmag}) : $signed({3'd0, qmag});

  // exp helpers
  logic signed [35:0] v36, e36, t36;
  assign v36 = {{4{level[31]}}, level};
  assign e36 = (v36 <<< 2) + (v36 <<< 1) - (36'sd6 <<< 30);
  assign t36 = e36 + (36'sd1 <<< 29);

  logic [33:0] g;
  logic [4:0]  nsh;
  assign nsh = 5'(-n_exp);
  always_comb begin
    if (n_exp >= 6'sd0) g = {1'b0, p} << n_exp[0];
    else g = {1'b0, p} >> nsh;
  end

  // output rounding
  logic signed [65:0] prnd;
  logic signed [35:0] rq;
  assign prnd = prod + (66'sd1 <<< 29);
  assign rq   = prnd[65:30];

  // shared multiplier operands
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (state) inside
      ST_RT_MUL, ST_ADV_MUL: begin
        a_op = $signed({18'd0, rate_raw(rate_byte)});
        b_op = $signed({17'd0, rate_scale});
      end
      ST_LOG_MUL: begin
        a_op = $signed({2'd0, m});
        b_op = $signed({2'd0, m});
      end
      ST_DIV: begin
        a_op = $signed({1'b0, rhi, dq[29:1]});
        b_op = DIV3_M;
      end
      ST_EXP_MUL: begin
        a_op = p;
        b_op = {{2{x_exp[30]}}, x_exp};
      end
      ST_OUT_MUL: begin
        a_op = {{(33-SB){sample[SB-1]}}, sample};
        b_op = gain;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= a_op * b_op;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_RETRIG;
      ST_RETRIG:   state_next = (retrig && !last_retrigger) ? ST_RT_MUL : ST_BRANCH;
      ST_RT_MUL:   state_next = ST_RT_USE;
      ST_RT_USE:   state_next = ST_BRANCH;
      ST_BRANCH: begin
        if (!envelope_enable) state_next = ST_FINISH;
        else if (gate || released) state_next = ST_MOVE;
        else if (level <= 32'sd0) state_next = ST_REL_ADV;
        else state_next = ST_LOG_NORM;
      end
      ST_LOG_NORM: if (m[30]) state_next = ST_LOG_MUL;
      ST_LOG_MUL:  state_next = ST_LOG_USE;
      ST_LOG_USE:  state_next = (cnt == 6'd0) ? ST_DIV_INIT : ST_LOG_MUL;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      state_next = ST_DIV_END;
      ST_DIV_END:  state_next = ST_REL_ADV;
      ST_REL_ADV:  state_next = (stage < 3'd5) ? ST_ADV_MUL : ST_MOVE;
      ST_ADV_MUL:  state_next = ST_ADV_USE;
      ST_ADV_USE:  state_next = adv_ret ? ST_MOVE : ST_GAIN;
      ST_MOVE: begin
        if (hit && stage < (gate ? 3'd2 : 3'd5)) state_next = ST_ADV_MUL;
        else state_next = ST_GAIN;
      end
      ST_GAIN:     state_next = gate ? ST_OUT_MUL : ST_EXP_MUL;
      ST_EXP_MUL:  state_next = ST_EXP_ADD;
      ST_EXP_ADD:  state_next = (cnt == 6'd2) ? ST_EXP_SH : ST_EXP_MUL;
      ST_EXP_SH:   state_next = ST_OUT_MUL;
      ST_OUT_MUL:  state_next = ST_OUT_RND;
      ST_OUT_RND:  state_next = ST_FINISH;
      ST_FINISH:   if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rate_codes      <= '0;
      level_codes     <= '0;
      envelope_enable <= 1'b0;
      rate_scale      <= RATE_SCALE_RST;
      level           <= '0;
      stage           <= '0;
      step_rate       <= '0;
      released        <= 1'b0;
      last_retrigger  <= 1'b0;
      m_tvalid        <= 1'b0;
      adv_ret         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (paddr[4:3])
          REG_RATE:   rate_codes      <= pwdata[47:0];
          REG_LEVEL:  level_codes     <= pwdata[47:0];
          REG_ENABLE: envelope_enable <= pwdata[0];
          default:    rate_scale      <= pwdata[15:0];
        endcase
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: if (s_tvalid) begin
          gate   <= s_tdata[0];
          retrig <= s_tdata[1];
          sample <= s_tdata[2 +: SB];
          agate  <= s_tdata[SB+2];
        end
        ST_RETRIG: begin
          last_retrigger <= retrig;
          if (retrig && !last_retrigger) begin
            stage    <= 3'd0;
            released <= 1'b0;
          end
        end
        ST_RT_USE: step_rate <= prod[36:5];
        ST_BRANCH: begin
          m    <= level[30:0];
          k    <= 5'd30;
          frac <= '0;
          cnt  <= 6'd29;
          if (envelope_enable && !gate && !released && level <= 32'sd0) begin
            level    <= 32'sh80000000;
            released <= 1'b1;
          end
          if (!envelope_enable) begin
            res      <= sample;
            res_done <= !agate;
          end
        end
        ST_LOG_NORM: if (!m[30]) begin
          m <= {m[29:0], 1'b0};
          k <= k - 5'd1;
        end
        ST_LOG_USE: begin
          if (mm[31]) begin
            frac[cnt[4:0]] <= 1'b1;
            m <= mm[31:1];
          end else begin
            m <= mm[30:0];
          end
          cnt <= cnt - 6'd1;
        end
        ST_DIV_INIT: begin
          neg <= lg[35];
          dq  <= lg[35] ? 35'(-lg) : lg[34:0];
        end
        ST_DIV_END: begin
          if (qs < -(36'sd1 <<< 31)) level <= 32'sh80000000;
          else level <= qs[31:0];
          released <= 1'b1;
        end
        ST_REL_ADV: begin
          adv_ret <= 1'b1;
          if (stage < 3'd5) stage <= stage + 3'd1;
        end
        ST_ADV_USE: begin
          // descend when the new target sits below the level
          if ($signed({2'd0, target}) < level) step_rate <= -prod[36:5];
          else step_rate <= prod[36:5];
        end
        ST_MOVE: begin
          adv_ret <= 1'b0;
          if (hit) begin
            level <= $signed({2'd0, target});
            if (stage < (gate ? 3'd2 : 3'd5)) stage <= stage + 3'd1;
          end else begin
            level <= nv_sat;
          end
        end
        ST_GAIN: begin
          gain  <= {level[31], level};
          n_exp <= t36[35:30];
          x_exp <= $signed({1'b0, t36[29:0]}) - (31'sd1 <<< 29);
          p     <= EXP_C3;
          cnt   <= 6'd0;
        end
        ST_EXP_ADD: begin
          case (cnt)
            6'd0:    p <= EXP_C2 + prod[62:30];
            6'd1:    p <= EXP_C1 + prod[62:30];
            default: p <= ONE_Q30 + prod[62:30];
          endcase
          cnt <= cnt + 6'd1;
        end
        ST_EXP_SH: begin
          if (n_exp >= 6'sd2 || g > 34'(ONE_Q30 <<< 1)) gain <= ONE_Q30 <<< 1;
          else gain <= $signed({1'b0, g[31:0]});
        end
        ST_OUT_RND: begin
          if (rq > SMAX) res <= SMAX[SB-1:0];
          else if (rq < SMIN) res <= SMIN[SB-1:0];
          else res <= rq[SB-1:0];
          res_done <= !gate && stage == 3'd5;
        end
        ST_FINISH: if (out_load) begin
          out_audio <= res;
          out_done  <= res_done;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {{(OW-SB-1){1'b0}}, out_done, out_audio};

endmodule

[design/sspe_checker.sv]
`timescale 1ns / 1ps
module sspe_checker
  import sspe_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OW = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [OW-1:0] m_tdata
);

  // the sequencer stays busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while sequencer busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind six_stage_patch_envelope sspe_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sspe_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/tb_six_stage_patch_envelope.sv]
`timescale 1ns / 1ps
module tb_six_stage_patch_envelope;
  import sspe_pkg::*;

  localparam longint ONE = 64'sd1 << 30;
  localparam longint SMAX = (64'sd1 << 23) - 1;
  localparam int WD_LIMIT = 5000;

  typedef struct {
    bit gate;
    bit retrig;
    bit agate;
    logic signed [23:0] audio;
  } sample_t;

  typedef struct {
    logic [23:0] audio_out;
    bit done;
  } scaled_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [31:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  six_stage_patch_envelope u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  sample_t pending_samples[$];
  scaled_t expected_out[$];
  int errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_releases = 0;
  bit noisy = 1'b1;
  bit hold_tx = 1'b0;
  int watchdog = 0;

  // envelope shadow state and register copies
  logic [47:0] cfg_rate_codes;
  logic [47:0] cfg_level_codes;
  bit cfg_enable;
  logic [15:0] cfg_rate_scale;
  int env_level;
  int env_stage;
  int env_rate;
  bit env_released;
  bit prev_retrig;

  function automatic int rate_for_stage(int i);
    logic [7:0] b;
    longint r;
    b = cfg_rate_codes[8*i +: 8];
    r = longint'(b[5:0]) << (3 * (3 - b[7:6]));
    return int'((r * longint'(cfg_rate_scale)) >>> 5);
  endfunction

  function automatic int target_for_stage(int i);
    return int'({cfg_level_codes[8*i +: 8], 22'd0});
  endfunction

  function automatic void advance_stage();
    env_stage = (env_stage < 5) ? env_stage + 1 : 5;
    env_rate = rate_for_stage(env_stage);
    if (target_for_stage(env_stage) < env_level) env_rate = -env_rate;
  endfunction

  function automatic void ramp_toward(int limit);
    longint nv;
    longint tgt;
    nv = longint'(env_level) + longint'(env_rate);
    tgt = longint'(target_for_stage(env_stage));
    if ((nv > tgt) != (env_rate < 0)) begin
      env_level = int'(tgt);
      if (env_stage < limit) advance_stage();
    end else begin
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      env_level = int'(nv);
    end
  endfunction

  function automatic int level_to_log(int v);
    longint unsigned m;
    longint lg;
    longint frac;
    int k;
    frac = 0;
    if (v <= 0) return -32'sd2147483648;
    k = 30;
    while (v[k] == 1'b0) k--;
    m = longint'(unsigned'(v)) << (30 - k);
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        frac = frac | (64'sd1 << i);
        m = m >> 1;
      end
    end
    lg = longint'(k - 24) * ONE + frac;
    lg = lg / 6;
    // smallest levels fall below the Q2.30 range
    if (lg < -64'sd2147483648) lg = -64'sd2147483648;
    return int'(lg);
  endfunction

  function automatic longint log_gain(int v);
    longint e;
    longint n;
    longint x;
    longint p;
    longint unsigned g;
    e = 6 * longint'(v) - 6 * ONE;
    n = (e + (ONE >>> 1)) >>> 30;
    x = e - n * ONE;
    p = 64'sd59597083;
    p = 64'sd257941248 + ((p * x) >>> 30);
    p = 64'sd744261118 + ((p * x) >>> 30);
    p = ONE + ((p * x) >>> 30);
    if (n >= 2) return 2 * ONE;
    if (n >= 0) g = longint'(p) << n;
    else g = longint'(p) >> (-n);
    if (g > 2 * ONE) g = 2 * ONE;
    return longint'(g);
  endfunction

  function automatic scaled_t scale_sample(sample_t s);
    scaled_t r;
    longint gain;
    longint res;
    if (s.retrig && !prev_retrig) begin
      env_stage = 0;
      env_released = 1'b0;
      env_rate = rate_for_stage(0);
    end
    prev_retrig = s.retrig;
    if (cfg_enable) begin
      if (s.gate) begin
        ramp_toward(2);
        gain = longint'(env_level);
      end else begin
        if (!env_released) begin
          env_level = level_to_log(env_level);
          env_released = 1'b1;
          n_releases++;
          if (env_stage < 5) advance_stage();
        end
        ramp_toward(5);
        gain = log_gain(env_level);
      end
      r.done = !s.gate && env_stage == 5;
      res = (longint'(s.audio) * gain + (ONE >>> 1)) >>> 30;
      if (res > SMAX) res = SMAX;
      if (res < -SMAX - 1) res = -SMAX - 1;
    end else begin
      r.done = !s.agate;
      res = longint'(s.audio);
    end
    r.audio_out = res[23:0];
    return r;
  endfunction

  // request side
  sample_t cur_sample;
  int tx_idle = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_out.insert(expected_out.size(), scale_sample(cur_sample));
        n_samples++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0 && !hold_tx) begin
          cur_sample = pending_samples.pop_front();
          s_tdata <= {5'd0, cur_sample.agate, cur_sample.audio, cur_sample.retrig,
                      cur_sample.gate};
          s_tvalid <= 1'b1;
          if (noisy && $urandom_range(0, 5) == 0) tx_idle = $urandom_range(1, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  int rx_stall = 0;
  scaled_t want;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_out.size() == 0) begin
          $error("unexpected result audio_out=%h done_res=%b", m_tdata[23:0], m_tdata[24]);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (m_tdata[23:0] !== want.audio_out) begin
            $error("audio_out expected %h actual %h", want.audio_out, m_tdata[23:0]);
            errors++;
          end
          if (m_tdata[24] !== want.done) begin
            $error("done_res expected %b actual %b", want.done, m_tdata[24]);
            errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (noisy && $urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'd0};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RATE: cfg_rate_codes = value[47:0];
      REG_LEVEL: cfg_level_codes = value[47:0];
      REG_ENABLE: cfg_enable = value[0];
      default: cfg_rate_scale = value[15:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_tvalid || expected_out.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_audio();
    case ($urandom_range(0, 7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic add_sample(bit g, bit rt, bit ag, logic signed [23:0] a);
    sample_t s;
    s.gate = g;
    s.retrig = rt;
    s.agate = ag;
    s.audio = a;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // note-shaped runs: segments with the gate held or released at random, with some noise
  task automatic add_notes(int count);
    int seg;
    bit g;
    for (int i = 0; i < count; i += seg) begin
      seg = $urandom_range(1, 40);
      g = 1'($urandom_range(0, 1));
      for (int j = 0; j < seg; j++) begin
        if ($urandom_range(0, 9) == 0)
          add_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), rand_audio());
        else
          add_sample(g, (j == 0) && g && ($urandom_range(0, 2) != 0),
                     1'($urandom_range(0, 1)), rand_audio());
      end
    end
  endtask

  task automatic random_config(bit extreme);
    if (extreme) begin
      reg_write(REG_RATE, $urandom_range(0, 1) ? 64'hffff_ffff_ffff : 64'h0);
      reg_write(REG_LEVEL, $urandom_range(0, 1) ? 64'hffff_ffff_ffff : 64'h0);
      reg_write(REG_SCALE, $urandom_range(0, 1) ? 64'hffff : 64'h0);
    end else begin
      reg_write(REG_RATE, {$urandom(), $urandom()});
      reg_write(REG_LEVEL, {$urandom(), $urandom()});
      reg_write(REG_SCALE, 64'($urandom_range(0, 65535)));
    end
    reg_write(REG_ENABLE, 64'($urandom_range(0, 5) != 0));
  endtask

  initial begin
    cfg_rate_codes = '0;
    cfg_level_codes = '0;
    cfg_enable = 1'b0;
    cfg_rate_scale = RATE_SCALE_RST;
    env_level = 0;
    env_stage = 0;
    env_rate = 0;
    env_released = 1'b0;
    prev_retrig = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bypass: unity gain, done is the inverse of the audio gate
    add_sample(1'b1, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b0, 1'b1, 1'b0, 24'sh800000);
    add_sample(1'b1, 1'b0, 1'b0, 24'sh000000);
    add_sample(1'b0, 1'b0, 1'b1, 24'sh000001);
    add_sample(1'b1, 1'b1, 1'b1, 24'shffffff);
    wait_drained();

    // enabled with zero level: release saturates the log value
    reg_write(REG_RATE, 64'h0000_3fbf_7fc8_4520);
    reg_write(REG_LEVEL, 64'h0000_0040_80c0_ff10);
    reg_write(REG_SCALE, 64'd16384);
    reg_write(REG_ENABLE, 64'd1);
    add_sample(1'b0, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b0, 1'b0, 1'b0, 24'sh800000);
    // retrigger edge, attack through sustain
    add_sample(1'b1, 1'b1, 1'b1, 24'sh7fffff);
    for (int i = 0; i < 8; i++) add_sample(1'b1, 1'b0, 1'b0, 24'sh800000);
    // release, then gate back on without retrigger, then off again
    for (int i = 0; i < 4; i++) add_sample(1'b0, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b1, 1'b0, 1'b1, 24'sh400000);
    add_sample(1'b1, 1'b0, 1'b1, 24'shc00000);
    add_sample(1'b0, 1'b0, 1'b0, 24'sh7fffff);
    add_sample(1'b0, 1'b1, 1'b0, 24'sh7fffff);
    add_sample(1'b1, 1'b0, 1'b0, 24'sh123456);
    wait_drained();

    // zero rates: level holds or snaps to target
    reg_write(REG_RATE, 64'h0);
    add_sample(1'b1, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b1, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b0, 1'b0, 1'b1, 24'sh7fffff);
    add_sample(1'b0, 1'b0, 1'b1, 24'sh7fffff);
    wait_drained();

    // hold the sender while the queue of notes fills
    hold_tx = 1'b1;
    add_notes(200);
    repeat (50) @(posedge clk);
    hold_tx = 1'b0;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph % 3 == 1);
      if (ph == 7) noisy = 1'b0;
      add_notes(230);
      wait_drained();
    end

    $display("%0d samples and %0d results checked, %0d releases to the log domain",
             n_samples, n_results, n_releases);
    $display("register settings included all-ones, all-zero and bypass");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sspe_pkg.sv
design/six_stage_patch_envelope.sv
design/sspe_checker.sv
tb/tb_six_stage_patch_envelope.sv
